### hdl/pva_pkg.sv
package pva_pkg;

  localparam int unsigned MaxVoices = 32;
  localparam int unsigned MaxInputs = 32;
  localparam int unsigned NoteW     = $clog2(MaxInputs);
  localparam int unsigned VoiceW    = $clog2(MaxVoices);
  localparam int unsigned CountW    = 6;

  localparam logic [CountW-1:0] NoVoice    = 6'h3F;
  localparam logic [15:0]       PitchReset = 16'h8000;

  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindStop  = 2'd2;

  localparam logic [1:0] EvNone   = 2'd0;
  localparam logic [1:0] EvStart  = 2'd1;
  localparam logic [1:0] EvStop   = 2'd2;
  localparam logic [1:0] EvUpdate = 2'd3;

  localparam logic RegVoices = 1'b0;
  localparam logic RegInputs = 1'b1;

  localparam logic [CountW-1:0] VoicesReset = 6'd3;
  localparam logic [CountW-1:0] InputsReset = 6'd10;

  typedef struct packed {
    logic [VoiceW-1:0] voice_index;
    logic [1:0]        voice_event;
    logic [15:0]       voice_pitch;
    logic [14:0]       voice_velocity;
    logic              index_error;
  } res_t;

  function automatic logic [CountW-1:0] used_voices(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = v;
    if (v == '0) r = CountW'(1);
    if (v > CountW'(MaxVoices)) r = CountW'(MaxVoices);
    return r;
  endfunction

  function automatic logic [CountW-1:0] used_inputs(input logic [CountW-1:0] n,
                                                    input logic [CountW-1:0] nv);
    logic [CountW-1:0] r;
    r = n;
    if (n > CountW'(MaxInputs)) r = CountW'(MaxInputs);
    if (r < nv) r = nv;
    return r;
  endfunction

endpackage

### hdl/pva_core.sv
module pva_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic [pva_pkg::CountW-1:0] nv_i,
  input  logic [pva_pkg::CountW-1:0] ni_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pva_pkg::NoteW-1:0]  input_index_i,
  input  logic [1:0]                 trigger_kind_i,
  input  logic [14:0]                velocity_i,
  input  logic [15:0]                note_pitch_i,
  output logic                       res_valid_o,
  input  logic                       res_take_i,
  output pva_pkg::res_t              res_o
);
  import pva_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOVE   = 3'd1;
  localparam logic [2:0] S_REMOVE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DROP   = 3'd4;
  localparam logic [2:0] S_ASSIGN = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]        st_q, st_d;
  logic [CountW-1:0] idx_q, idx_d, k_q, k_d, held_q, held_d;
  logic [NoteW-1:0]  note_q, note_d, carry_q, carry_d, heir_q, heir_d;
  logic              heir_v_q, heir_v_d;
  logic [1:0]        kind_q, kind_d;
  logic [15:0]       pitch_q, pitch_d;
  logic [14:0]       vel_q, vel_d;
  logic [CountW-1:0] freed_q, freed_d;
  logic [MaxVoices-1:0] busy_q, busy_d, busy_init;
  res_t              res_q, res_d;

  logic [NoteW-1:0]  list_q [MaxInputs];
  logic [CountW-1:0] voice_q [MaxInputs];
  logic [15:0]       pst_q [MaxInputs];
  logic [14:0]       vst_q [MaxInputs];

  logic [NoteW-1:0]  l_rd;
  logic [CountW-1:0] v_rd, v_note, span;
  logic              lw_en, vw_en, pw_en, velw_en;
  logic [NoteW-1:0]  lw_addr, vw_addr;
  logic [NoteW-1:0]  lw_data;
  logic [CountW-1:0] vw_data;
  logic              fr_found;
  logic [VoiceW-1:0] fr_sel;

  assign l_rd   = list_q[idx_q[NoteW-1:0]];
  assign v_rd   = voice_q[l_rd];
  assign v_note = voice_q[note_q];
  assign span   = (held_q < nv_i) ? held_q : nv_i;

  always_comb begin
    for (int b = 0; b < MaxVoices; b++) begin
      busy_init[b] = (CountW'(b) >= nv_i);
    end
  end

  // lowest free voice
  always_comb begin
    fr_found = 1'b0;
    fr_sel   = '0;
    for (int b = MaxVoices - 1; b >= 0; b--) begin
      if (!busy_q[b]) begin
        fr_found = 1'b1;
        fr_sel   = VoiceW'(b);
      end
    end
  end

  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    k_d      = k_q;
    held_d   = held_q;
    note_d   = note_q;
    carry_d  = carry_q;
    heir_d   = heir_q;
    heir_v_d = heir_v_q;
    kind_d   = kind_q;
    pitch_d  = pitch_q;
    vel_d    = vel_q;
    freed_d  = freed_q;
    busy_d   = busy_q;
    res_d    = res_q;
    lw_en    = 1'b0;
    lw_addr  = idx_q[NoteW-1:0];
    lw_data  = carry_q;
    vw_en    = 1'b0;
    vw_addr  = l_rd;
    vw_data  = NoVoice;
    pw_en    = 1'b0;
    velw_en  = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          note_d   = input_index_i;
          carry_d  = input_index_i;
          kind_d   = trigger_kind_i;
          pitch_d  = note_pitch_i;
          vel_d    = velocity_i;
          heir_v_d = 1'b0;
          freed_d  = NoVoice;
          idx_d    = '0;
          k_d      = '0;
          res_d    = '0;
          if ({1'b0, input_index_i} >= ni_i) begin
            res_d.index_error = 1'b1;
            st_d = S_DONE;
          end else begin
            pw_en = 1'b1;
            case (trigger_kind_i)
              KindStart: begin
                velw_en = 1'b1;
                st_d    = S_MOVE;
              end
              KindStop: begin
                freed_d = voice_q[input_index_i];
                vw_en   = 1'b1;
                vw_addr = input_index_i;
                st_d    = S_REMOVE;
              end
              default: begin
                if (voice_q[input_index_i] < nv_i) begin
                  res_d.voice_event = EvUpdate;
                  res_d.voice_index = voice_q[input_index_i][VoiceW-1:0];
                  res_d.voice_pitch = note_pitch_i;
                end
                st_d = S_DONE;
              end
            endcase
          end
        end
      end
      S_MOVE: begin
        // shift the list down by one until the old place of the note
        if (idx_q < held_q) begin
          lw_en = 1'b1;
          if (l_rd == note_q) begin
            idx_d  = '0;
            busy_d = busy_init;
            st_d   = S_SCAN;
          end else begin
            carry_d = l_rd;
            idx_d   = idx_q + 1'b1;
          end
        end else begin
          if (held_q < CountW'(MaxInputs)) begin
            lw_en   = 1'b1;
            lw_addr = held_q[NoteW-1:0];
            held_d  = held_q + 1'b1;
          end
          idx_d  = '0;
          busy_d = busy_init;
          st_d   = S_SCAN;
        end
      end
      S_REMOVE: begin
        if (idx_q < held_q) begin
          if (l_rd != note_q) begin
            lw_en   = 1'b1;
            lw_addr = k_q[NoteW-1:0];
            lw_data = l_rd;
            k_d     = k_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end else begin
          held_d = k_q;
          idx_d  = '0;
          busy_d = busy_init;
          st_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q < span) begin
          if (v_rd < nv_i) busy_d[v_rd[VoiceW-1:0]] = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          st_d = S_DROP;
        end
      end
      S_DROP: begin
        if (idx_q < held_q) begin
          vw_en = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          idx_d = '0;
          st_d  = S_ASSIGN;
        end
      end
      S_ASSIGN: begin
        if (idx_q < span) begin
          if (v_rd >= nv_i) begin
            vw_en = 1'b1;
            if (fr_found) begin
              vw_data        = {1'b0, fr_sel};
              busy_d[fr_sel] = 1'b1;
              if ({1'b0, fr_sel} == freed_q) begin
                heir_d   = l_rd;
                heir_v_d = 1'b1;
              end
            end
          end
          idx_d = idx_q + 1'b1;
        end else begin
          st_d = S_REPORT;
        end
      end
      S_REPORT: begin
        if (kind_q == KindStart) begin
          if (v_note < nv_i) begin
            res_d.voice_event    = EvStart;
            res_d.voice_index    = v_note[VoiceW-1:0];
            res_d.voice_pitch    = pitch_q;
            res_d.voice_velocity = vel_q;
          end
        end else if (freed_q < nv_i) begin
          res_d.voice_index = freed_q[VoiceW-1:0];
          if (heir_v_q) begin
            res_d.voice_event    = EvStart;
            res_d.voice_pitch    = pst_q[heir_q];
            res_d.voice_velocity = vst_q[heir_q];
          end else begin
            res_d.voice_event = EvStop;
            res_d.voice_pitch = pitch_q;
          end
        end
        st_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      held_q   <= '0;
      heir_v_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      heir_v_q <= heir_v_d;
      held_q   <= clr_i ? '0 : held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxInputs; i++) begin
        voice_q[i] <= NoVoice;
        pst_q[i]   <= PitchReset;
      end
    end else if (clr_i) begin
      for (int i = 0; i < MaxInputs; i++) begin
        voice_q[i] <= NoVoice;
        pst_q[i]   <= PitchReset;
      end
    end else begin
      if (vw_en) voice_q[vw_addr] <= vw_data;
      if (pw_en) pst_q[note_d] <= pitch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    k_q     <= k_d;
    note_q  <= note_d;
    carry_q <= carry_d;
    heir_q  <= heir_d;
    kind_q  <= kind_d;
    pitch_q <= pitch_d;
    vel_q   <= vel_d;
    freed_q <= freed_d;
    busy_q  <= busy_d;
    res_q   <= res_d;
    if (lw_en) list_q[lw_addr] <= lw_data;
    if (velw_en) vst_q[note_d] <= vel_d;
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign res_valid_o = (st_q == S_DONE);
  assign res_o       = res_q;

endmodule

### hdl/polyphonic_voice_allocator_unit.sv
// A pitch beat or an index error goes from idle straight to done in the core; the result is
// then registered in the output buffer that drives out_valid_o. A start beat walks the move,
// scan, drop, assign and report states; a stop beat replaces move with remove.
// One beat at a time: in_ready_o is low until the result is taken into the output buffer.
// Reset: no note held, all voices unassigned, all stored pitches at the lowest
// value, voices_in_use 3, inputs_in_use 10. A register write clears the first three again.
module polyphonic_voice_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [2:0]                paddr_i,
  input  logic [31:0]               pwdata_i,
  output logic [31:0]               prdata_o,
  output logic                      pready_o,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pva_pkg::NoteW-1:0] input_index_i,
  input  logic [1:0]                trigger_kind_i,
  input  logic [14:0]               velocity_i,
  input  logic signed [15:0]        note_pitch_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pva_pkg::VoiceW-1:0] voice_index_o,
  output logic [1:0]                voice_event_o,
  output logic signed [15:0]        voice_pitch_o,
  output logic [14:0]               voice_velocity_o,
  output logic                      index_error_o
);
  import pva_pkg::*;

  logic [CountW-1:0] voices_q, inputs_q, nv, ni;
  logic              wr, res_valid, take, ov_q;
  res_t              res, out_q;

  assign wr       = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == RegInputs) ? {26'd0, inputs_q} : {26'd0, voices_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voices_q <= VoicesReset;
      inputs_q <= InputsReset;
    end else if (wr) begin
      if (paddr_i[2] == RegVoices) voices_q <= pwdata_i[CountW-1:0];
      else inputs_q <= pwdata_i[CountW-1:0];
    end
  end

  assign nv = used_voices(voices_q);
  assign ni = used_inputs(inputs_q, nv);

  pva_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clr_i          (wr),
    .nv_i           (nv),
    .ni_i           (ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .input_index_i  (input_index_i),
    .trigger_kind_i (trigger_kind_i),
    .velocity_i     (velocity_i),
    .note_pitch_i   (note_pitch_i),
    .res_valid_o    (res_valid),
    .res_take_i     (take),
    .res_o          (res)
  );

  // hold the result beat until taken
  assign take = res_valid & (~ov_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (take) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= res;
  end

  assign out_valid_o      = ov_q;
  assign voice_index_o    = out_q.voice_index;
  assign voice_event_o    = out_q.voice_event;
  assign voice_pitch_o    = out_q.voice_pitch;
  assign voice_velocity_o = out_q.voice_velocity;
  assign index_error_o    = out_q.index_error;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a beat is in work");

  a_error_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_error_o) |-> (voice_event_o == EvNone))
    else $error("event reported with index error");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && voice_event_o == EvNone) |->
      (voice_index_o == '0 && voice_pitch_o == '0 && voice_velocity_o == '0))
    else $error("idle result carries data");

  a_velocity_start_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && voice_event_o != EvStart) |-> (voice_velocity_o == '0))
    else $error("velocity on a non-start event");

endmodule

### tb/polyphonic_voice_allocator_unit_tb.sv
module polyphonic_voice_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pva_pkg::*;

  localparam logic [1:0] KindPitch = 2'd0;
  localparam logic [1:0] KindSpare = 2'd3;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned LongHoldCycles = 400;

  class voice_scoreboard;
    logic [5:0]  voices_reg, inputs_reg;
    logic [4:0]  recency[32];
    logic [5:0]  held;
    logic [5:0]  voice_of[32];
    logic [15:0] pitch_of[32];
    logic [14:0] vel_of[32];
    res_t        pending[$];
    int          errors;

    function new();
      voices_reg = VoicesReset;
      inputs_reg = InputsReset;
      errors = 0;
      foreach (vel_of[i]) vel_of[i] = '0;
      clear_notes();
    endfunction

    function void clear_notes();
      held = '0;
      foreach (voice_of[i]) begin
        voice_of[i] = NoVoice;
        pitch_of[i] = PitchReset;
        recency[i]  = '0;
      end
    endfunction

    function int n_voices();
      int v;
      v = voices_reg;
      if (v < 1) v = 1;
      if (v > MaxVoices) v = MaxVoices;
      return v;
    endfunction

    function int n_inputs();
      int n;
      n = inputs_reg;
      if (n > MaxInputs) n = MaxInputs;
      if (n < n_voices()) n = n_voices();
      return n;
    endfunction

    function int span();
      return (held < n_voices()) ? int'(held) : n_voices();
    endfunction

    function void write_reg(logic sel, logic [5:0] value);
      if (sel == RegVoices) voices_reg = value;
      else inputs_reg = value;
      clear_notes();
    endfunction

    function void drop_note(int note);
      int k;
      k = 0;
      for (int i = 0; i < held; i++)
        if (recency[i] != note) begin
          recency[k] = recency[i];
          k++;
        end
      held = 6'(k);
    endfunction

    function void allocate();
      logic [31:0] busy;
      int nv, sp, n;
      nv = n_voices();
      sp = span();
      for (int v = 0; v < 32; v++) busy[v] = (v >= nv);
      for (int i = 0; i < sp; i++)
        if (voice_of[recency[i]] < nv) busy[voice_of[recency[i]]] = 1'b1;
      for (int i = sp; i < held; i++) voice_of[recency[i]] = NoVoice;
      for (int i = 0; i < sp; i++) begin
        n = recency[i];
        if (voice_of[n] < nv) continue;
        voice_of[n] = NoVoice;
        for (int v = 0; v < nv; v++)
          if (!busy[v]) begin
            busy[v] = 1'b1;
            voice_of[n] = 6'(v);
            break;
          end
      end
    endfunction

    function void note_event(logic [4:0] idx, logic [1:0] kind, logic [14:0] vel,
                             logic [15:0] pitch);
      res_t r;
      int nv, heir;
      logic [5:0] freed;
      r = '0;
      nv = n_voices();
      if (idx >= n_inputs()) begin
        r.index_error = 1'b1;
      end else begin
        pitch_of[idx] = pitch;
        if (kind == KindStart) begin
          vel_of[idx] = vel;
          drop_note(idx);
          for (int i = 31; i > 0; i--) recency[i] = recency[i-1];
          recency[0] = idx;
          if (held < 32) held++;
          allocate();
          if (voice_of[idx] < nv) begin
            r.voice_event = EvStart;
            r.voice_index = 5'(voice_of[idx]);
            r.voice_pitch = pitch;
            r.voice_velocity = vel;
          end
        end else if (kind == KindStop) begin
          freed = voice_of[idx];
          heir = -1;
          drop_note(idx);
          voice_of[idx] = NoVoice;
          allocate();
          if (freed < nv) begin
            for (int i = 0; i < span(); i++)
              if (voice_of[recency[i]] == freed) begin
                heir = recency[i];
                break;
              end
            r.voice_index = 5'(freed);
            if (heir >= 0) begin
              r.voice_event = EvStart;
              r.voice_pitch = pitch_of[heir];
              r.voice_velocity = vel_of[heir];
            end else begin
              r.voice_event = EvStop;
              r.voice_pitch = pitch;
            end
          end
        end else if (voice_of[idx] < nv) begin
          r.voice_event = EvUpdate;
          r.voice_index = 5'(voice_of[idx]);
          r.voice_pitch = pitch;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.voice_index !== want.voice_index) begin
        $error("voice_index: expected %0d, got %0d", want.voice_index, got.voice_index);
        errors++;
      end
      if (got.voice_event !== want.voice_event) begin
        $error("voice_event: expected %0d, got %0d", want.voice_event, got.voice_event);
        errors++;
      end
      if (got.voice_pitch !== want.voice_pitch) begin
        $error("voice_pitch: expected %0d, got %0d",
               $signed(want.voice_pitch), $signed(got.voice_pitch));
        errors++;
      end
      if (got.voice_velocity !== want.voice_velocity) begin
        $error("voice_velocity: expected %0d, got %0d",
               want.voice_velocity, got.voice_velocity);
        errors++;
      end
      if (got.index_error !== want.index_error) begin
        $error("index_error: expected %0d, got %0d", want.index_error, got.index_error);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel_i, penable_i, pwrite_i;
  logic [2:0] paddr_i;
  logic [31:0] pwdata_i, prdata_o;
  logic pready_o;
  logic in_valid_i, in_ready_o;
  logic [NoteW-1:0] input_index_i;
  logic [1:0] trigger_kind_i;
  logic [14:0] velocity_i;
  logic signed [15:0] note_pitch_i;
  logic out_valid_o, out_ready_i;
  logic [VoiceW-1:0] voice_index_o;
  logic [1:0] voice_event_o;
  logic signed [15:0] voice_pitch_o;
  logic [14:0] voice_velocity_o;
  logic index_error_o;

  voice_scoreboard sb = new();
  bit long_hold_req;
  int burst_left;

  polyphonic_voice_allocator_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // receiver: shifting stall pattern, plus a long hold on request
  initial begin
    int mode, mode_left, hold_left;
    out_ready_i = 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 0);
          2: out_ready_i <= ($urandom_range(0, 9) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{voice_index_o, voice_event_o, voice_pitch_o,
                        voice_velocity_o, index_error_o});

  task automatic send_note(logic [4:0] idx, logic [1:0] kind, logic [14:0] vel,
                           logic [15:0] pitch);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    input_index_i <= idx;
    trigger_kind_i <= kind;
    velocity_i <= vel;
    note_pitch_i <= pitch;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_event(idx, kind, vel, pitch);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_reg(logic sel, logic [5:0] value);
    @(negedge clk_i);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    penable_i <= 1'b0;
    paddr_i <= (sel == RegVoices) ? 3'd0 : 3'd4;
    pwdata_i <= {26'd0, value};
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(sel, value);
    @(negedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
  endtask

  task automatic reconfigure(logic [5:0] voices, logic [5:0] inputs);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    set_reg(RegVoices, voices);
    set_reg(RegInputs, inputs);
  endtask

  task automatic random_notes(int count);
    logic [4:0] idx;
    logic [1:0] kind;
    int pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) idx = 5'($urandom());
      else idx = 5'($urandom_range(0, sb.n_inputs() - 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = KindStart;
      else if (pick < 75) kind = KindStop;
      else if (pick < 95) kind = KindPitch;
      else kind = KindSpare;
      send_note(idx, kind, 15'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    logic [5:0] voices_set[8] = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd4, 6'd2, 6'd8, 6'd31};
    logic [5:0] inputs_set[8] = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd40, 6'd31, 6'd16, 6'd5};
    rst_ni = 1'b0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    in_valid_i = 1'b0;
    input_index_i = '0;
    trigger_kind_i = '0;
    velocity_i = '0;
    note_pitch_i = '0;
    long_hold_req = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset config: three voices over ten inputs
    send_note(5'd0, KindPitch, 15'd0, 16'h8000);
    send_note(5'd0, KindStart, 15'd0, 16'h7FFF);
    send_note(5'd1, KindStart, 15'h7FFF, 16'h8000);
    send_note(5'd2, KindStart, 15'd100, 16'd5);
    send_note(5'd3, KindStart, 15'd200, 16'hFFFF);
    send_note(5'd0, KindPitch, 15'd0, 16'd77);
    send_note(5'd1, KindStart, 15'd300, 16'd12);
    send_note(5'd2, KindSpare, 15'd0, 16'h1234);
    send_note(5'd3, KindStop, 15'd0, 16'd9);
    send_note(5'd0, KindStop, 15'd0, 16'd3);
    send_note(5'd4, KindStart, 15'd1, 16'd4);
    send_note(5'd1, KindStop, 15'd0, 16'd50);
    send_note(5'd10, KindStart, 15'h7FFF, 16'h7FFF);
    send_note(5'd31, KindStop, 15'd0, 16'h8000);
    send_note(5'd9, KindStart, 15'h5555, 16'h2AAA);
    send_note(5'd9, KindStop, 15'd0, 16'h5555);
    send_note(5'd2, KindStop, 15'd0, 16'd1);
    send_note(5'd4, KindStop, 15'd0, 16'd2);
    send_note(5'd4, KindStop, 15'd0, 16'd2);

    for (int p = 0; p < 8; p++) begin
      reconfigure(voices_set[p], inputs_set[p]);
      if (p == 1) long_hold_req = 1'b1;
      random_notes(33);
      if (p == 4) drain();
      random_notes(33);
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
